// ===== rtl/tcfu_pkg.sv =====
package tcfu_pkg;

	localparam int CW = 32;
	localparam int FRAC = 16;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int NW = SW + FRAC;
	localparam int ITW = $clog2(CW);

	typedef struct packed {
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic signed [CW-1:0] tex_u;
		logic signed [CW-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic [2:0][DW-1:0] e1;
		logic [2:0][DW-1:0] e2;
		logic signed [DW-1:0] d1u;
		logic signed [DW-1:0] d1v;
		logic signed [DW-1:0] d2u;
		logic signed [DW-1:0] d2v;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIVSET,
		B_DIV,
		B_FIN,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/tcfu_vtx_if.sv =====
interface tcfu_vtx_if;
	logic valid;
	logic ready;
	logic signed [tcfu_pkg::CW-1:0] pos_x;
	logic signed [tcfu_pkg::CW-1:0] pos_y;
	logic signed [tcfu_pkg::CW-1:0] pos_z;
	logic signed [tcfu_pkg::CW-1:0] tex_u;
	logic signed [tcfu_pkg::CW-1:0] tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ===== rtl/tcfu_tan_if.sv =====
interface tcfu_tan_if;
	logic valid;
	logic ready;
	logic signed [tcfu_pkg::CW-1:0] tangent_x;
	logic signed [tcfu_pkg::CW-1:0] tangent_y;
	logic signed [tcfu_pkg::CW-1:0] tangent_z;
	logic degenerate;
	logic saturated;

	modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, saturated,
		input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, saturated,
		output ready);
endinterface

// ===== rtl/triangle_tangent_from_uv_top.sv =====
// A tangent transaction is produced for each triangle after its third corner is accepted;
// if the uv determinant is zero, the divider is skipped and degenerate is set.
// The back end takes one job at a time; its restoring divider retires one quotient bit
// per cycle over 32 bits for each of the three components, unless that component overflows.
// Two triangles can wait in the job queue while the divider works.
// Reset (arst_n low) clears the corner count, the stored corners, the queue and the output valid.
module triangle_tangent_from_uv_top (
	input  logic       clk,
	input  logic       arst_n,
	tcfu_vtx_if.sink   vtx,
	tcfu_tan_if.source tan
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	tcfu_pkg::job_t push_job, pop_job;

	tcfu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	tcfu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	tcfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.tan       (tan)
	);

endmodule

// ===== rtl/tcfu_front.sv =====
module tcfu_front (
	input  logic            clk,
	input  logic            arst_n,
	tcfu_vtx_if.sink        vtx,
	output logic            push_valid,
	input  logic            push_ready,
	output tcfu_pkg::job_t  push_job
);

	logic [1:0] count_q;
	tcfu_pkg::vertex_t c0_q, c1_q, cur;
	logic third;
	logic accept;

	assign cur.pos_x = vtx.pos_x;
	assign cur.pos_y = vtx.pos_y;
	assign cur.pos_z = vtx.pos_z;
	assign cur.tex_u = vtx.tex_u;
	assign cur.tex_v = vtx.tex_v;

	assign third = (count_q >= 2'd2);
	assign vtx.ready = !third || push_ready;
	assign push_valid = vtx.valid && third;
	assign accept = vtx.valid && vtx.ready;

	function automatic logic [tcfu_pkg::DW-1:0] dif(
		input logic [tcfu_pkg::CW-1:0] a,
		input logic [tcfu_pkg::CW-1:0] b
	);
		return {a[tcfu_pkg::CW-1], a} - {b[tcfu_pkg::CW-1], b};
	endfunction

	always_comb begin
		push_job.e1[0] = dif(c1_q.pos_x, c0_q.pos_x);
		push_job.e1[1] = dif(c1_q.pos_y, c0_q.pos_y);
		push_job.e1[2] = dif(c1_q.pos_z, c0_q.pos_z);
		push_job.e2[0] = dif(cur.pos_x, c0_q.pos_x);
		push_job.e2[1] = dif(cur.pos_y, c0_q.pos_y);
		push_job.e2[2] = dif(cur.pos_z, c0_q.pos_z);
		push_job.d1u = dif(c1_q.tex_u, c0_q.tex_u);
		push_job.d1v = dif(c1_q.tex_v, c0_q.tex_v);
		push_job.d2u = dif(cur.tex_u, c0_q.tex_u);
		push_job.d2v = dif(cur.tex_v, c0_q.tex_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			c0_q <= '0;
			c1_q <= '0;
		end else if (accept) begin
			if (third) begin
				count_q <= 2'd0;
			end else begin
				count_q <= count_q + 2'd1;
				if (count_q[0]) begin
					c1_q <= cur;
				end else begin
					c0_q <= cur;
				end
			end
		end
	end

endmodule

// ===== rtl/tcfu_queue.sv =====
module tcfu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tcfu_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tcfu_pkg::job_t  pop_job
);

	tcfu_pkg::job_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_job = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/tcfu_back.sv =====
module tcfu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  tcfu_pkg::job_t  job,
	tcfu_tan_if.source      tan
);

	localparam int CW = tcfu_pkg::CW;
	localparam int DW = tcfu_pkg::DW;
	localparam int PW = tcfu_pkg::PW;
	localparam int SW = tcfu_pkg::SW;
	localparam int NW = tcfu_pkg::NW;
	localparam int FRAC = tcfu_pkg::FRAC;
	localparam int ITW = tcfu_pkg::ITW;

	tcfu_pkg::back_state_t state_q, state_d;
	tcfu_pkg::job_t job_q;

	logic [3:0] cnt_q;
	logic [ITW-1:0] it_q;
	logic [1:0] k_q;

	logic signed [DW-1:0] op_a, op_b;
	logic signed [PW-1:0] prod, prod_q, hold_q;
	logic signed [SW-1:0] diff;
	logic signed [SW-1:0] det_q;
	logic signed [SW-1:0] num_q [3];
	logic [SW-1:0] dmag_q;

	logic [SW-1:0] nmag;
	logic [NW-1:0] nfull;
	logic ovf;
	logic ovf_q, neg_q;
	logic [SW:0] r_q, r_sh;
	logic [CW-1:0] nlo_q, q_q;
	logic r_ge;

	logic signed [CW-1:0] t_q [3];
	logic sat_q, deg_q;
	logic signed [CW-1:0] fin_val;
	logic fin_sat;

	logic out_free;

	assign job_ready = (state_q == tcfu_pkg::B_IDLE);
	assign out_free = !tan.valid || tan.ready;

	// One shared multiplier; products alternate between the two terms of a difference.
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin op_a = job_q.d1u; op_b = job_q.d2v; end
			3'd1: begin op_a = job_q.d2u; op_b = job_q.d1v; end
			3'd2: begin op_a = job_q.d2v; op_b = $signed(job_q.e1[0]); end
			3'd3: begin op_a = job_q.d1v; op_b = $signed(job_q.e2[0]); end
			3'd4: begin op_a = job_q.d2v; op_b = $signed(job_q.e1[1]); end
			3'd5: begin op_a = job_q.d1v; op_b = $signed(job_q.e2[1]); end
			3'd6: begin op_a = job_q.d2v; op_b = $signed(job_q.e1[2]); end
			default: begin op_a = job_q.d1v; op_b = $signed(job_q.e2[2]); end
		endcase
	end

	assign prod = op_a * op_b;
	assign diff = $signed({hold_q[PW-1], hold_q}) - $signed({prod_q[PW-1], prod_q});

	always_comb begin
		nmag = num_q[k_q][SW-1] ? SW'(-num_q[k_q]) : num_q[k_q];
		nfull = {nmag, {FRAC{1'b0}}};
		ovf = ({{(CW-FRAC){1'b0}}, nfull} >= {dmag_q, {CW{1'b0}}});
		r_sh = {r_q[SW-1:0], nlo_q[CW-1]};
		r_ge = (r_sh >= {1'b0, dmag_q});
	end

	// Final sign, magnitude limit and clip for one component.
	always_comb begin
		fin_sat = 1'b0;
		if (ovf_q) begin
			fin_sat = 1'b1;
			fin_val = neg_q ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else if (neg_q) begin
			if (q_q > {1'b1, {(CW-1){1'b0}}}) begin
				fin_sat = 1'b1;
				fin_val = {1'b1, {(CW-1){1'b0}}};
			end else begin
				fin_val = -q_q;
			end
		end else begin
			if (q_q[CW-1]) begin
				fin_sat = 1'b1;
				fin_val = {1'b0, {(CW-1){1'b1}}};
			end else begin
				fin_val = q_q;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcfu_pkg::B_IDLE: begin
				if (job_valid) begin
					state_d = tcfu_pkg::B_MUL;
				end
			end
			tcfu_pkg::B_MUL: begin
				if (cnt_q == 4'd8) begin
					state_d = tcfu_pkg::B_DIVSET;
				end else if (cnt_q == 4'd2 && diff == '0) begin
					state_d = tcfu_pkg::B_OUT;
				end
			end
			tcfu_pkg::B_DIVSET: begin
				state_d = ovf ? tcfu_pkg::B_FIN : tcfu_pkg::B_DIV;
			end
			tcfu_pkg::B_DIV: begin
				if (it_q == ITW'(CW - 1)) begin
					state_d = tcfu_pkg::B_FIN;
				end
			end
			tcfu_pkg::B_FIN: begin
				state_d = (k_q == 2'd2) ? tcfu_pkg::B_OUT : tcfu_pkg::B_DIVSET;
			end
			tcfu_pkg::B_OUT: begin
				if (out_free) begin
					state_d = tcfu_pkg::B_IDLE;
				end
			end
			default: state_d = tcfu_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcfu_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			it_q <= '0;
			k_q <= '0;
			deg_q <= 1'b0;
			sat_q <= 1'b0;
			tan.valid <= 1'b0;
		end else begin
			if (state_q == tcfu_pkg::B_OUT && out_free) begin
				tan.valid <= 1'b1;
			end else if (tan.valid && tan.ready) begin
				tan.valid <= 1'b0;
			end
			case (state_q)
				tcfu_pkg::B_IDLE: begin
					cnt_q <= '0;
					k_q <= '0;
					deg_q <= 1'b0;
					sat_q <= 1'b0;
				end
				tcfu_pkg::B_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2 && diff == '0) begin
						deg_q <= 1'b1;
					end
				end
				tcfu_pkg::B_DIVSET: begin
					it_q <= '0;
				end
				tcfu_pkg::B_DIV: begin
					it_q <= it_q + ITW'(1);
				end
				tcfu_pkg::B_FIN: begin
					k_q <= k_q + 2'd1;
					sat_q <= sat_q | fin_sat;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tcfu_pkg::B_IDLE: begin
				job_q <= job;
			end
			tcfu_pkg::B_MUL: begin
				prod_q <= prod;
				// The first term of each pair is held while the second is formed.
				if (cnt_q[0]) begin
					hold_q <= prod_q;
				end
				if (cnt_q == 4'd2) begin
					det_q <= diff;
					dmag_q <= diff[SW-1] ? SW'(-diff) : diff;
				end else if (cnt_q == 4'd4) begin
					num_q[0] <= diff;
				end else if (cnt_q == 4'd6) begin
					num_q[1] <= diff;
				end else if (cnt_q == 4'd8) begin
					num_q[2] <= diff;
				end
			end
			tcfu_pkg::B_DIVSET: begin
				ovf_q <= ovf;
				neg_q <= num_q[k_q][SW-1] ^ det_q[SW-1];
				r_q <= (SW+1)'(nfull[NW-1:CW]);
				nlo_q <= nfull[CW-1:0];
				q_q <= '0;
			end
			tcfu_pkg::B_DIV: begin
				r_q <= r_ge ? (r_sh - {1'b0, dmag_q}) : r_sh;
				q_q <= {q_q[CW-2:0], r_ge};
				nlo_q <= {nlo_q[CW-2:0], 1'b0};
			end
			tcfu_pkg::B_FIN: begin
				t_q[k_q] <= fin_val;
			end
			tcfu_pkg::B_OUT: begin
				if (out_free) begin
					tan.degenerate <= deg_q;
					tan.saturated <= deg_q ? 1'b0 : sat_q;
					tan.tangent_x <= deg_q ? '0 : t_q[0];
					tan.tangent_y <= deg_q ? '0 : t_q[1];
					tan.tangent_z <= deg_q ? '0 : t_q[2];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== dv/tb_triangle_tangent_from_uv_top.sv =====
module tb_triangle_tangent_from_uv_top;

	localparam int CW = tcfu_pkg::CW;
	localparam int FRAC = tcfu_pkg::FRAC;
	typedef tcfu_pkg::vertex_t vertex_t;

	localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [CW-1:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [CW-1:0] MINV = 32'sh8000_0000;

	typedef struct packed {
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
		logic signed [CW-1:0] tz;
		logic deg;
		logic sat;
	} tangent_t;

	logic clk;
	logic arst_n;

	tcfu_vtx_if vtx_ch();
	tcfu_tan_if tan_ch();

	triangle_tangent_from_uv_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx_ch),
		.tan(tan_ch)
	);

	tangent_t tangent_q[$];
	vertex_t held_corner[2];
	int corners_held;
	int mismatches;
	int rx_hold;
	bit tx_fast;
	bit rx_fast;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic vertex_t mk_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
		logic signed [CW-1:0] z, logic signed [CW-1:0] u, logic signed [CW-1:0] v);
		vertex_t r;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.tex_u = u;
		r.tex_v = v;
		return r;
	endfunction

	function automatic logic signed [127:0] field_of(vertex_t c, int k);
		case (k)
			0: return $signed(c.pos_x);
			1: return $signed(c.pos_y);
			2: return $signed(c.pos_z);
			3: return $signed(c.tex_u);
			default: return $signed(c.tex_v);
		endcase
	endfunction

	function automatic tangent_t triangle_tangent(vertex_t c0, vertex_t c1, vertex_t c2);
		tangent_t r;
		logic signed [127:0] d1u, d1v, d2u, d2v, det, num, q;
		logic signed [127:0] e1, e2;
		logic signed [CW-1:0] t[3];
		r = '0;
		d1u = field_of(c1, 3) - field_of(c0, 3);
		d1v = field_of(c1, 4) - field_of(c0, 4);
		d2u = field_of(c2, 3) - field_of(c0, 3);
		d2v = field_of(c2, 4) - field_of(c0, 4);
		det = d1u * d2v - d2u * d1v;
		if (det == 0) begin
			r.deg = 1'b1;
			return r;
		end
		for (int k = 0; k < 3; k++) begin
			e1 = field_of(c1, k) - field_of(c0, k);
			e2 = field_of(c2, k) - field_of(c0, k);
			num = d2v * e1 - d1v * e2;
			// Signed division truncates toward zero, as the divider does.
			q = (num <<< FRAC) / det;
			if (q > $signed(128'sd2147483647)) begin
				q = 128'sd2147483647;
				r.sat = 1'b1;
			end else if (q < -$signed(128'sd2147483648)) begin
				q = -128'sd2147483648;
				r.sat = 1'b1;
			end
			t[k] = q[CW-1:0];
		end
		r.tx = t[0];
		r.ty = t[1];
		r.tz = t[2];
		return r;
	endfunction

	function automatic void accept_corner(vertex_t c);
		if (corners_held < 2) begin
			held_corner[corners_held] = c;
			corners_held++;
		end else begin
			tangent_q = {tangent_q, triangle_tangent(held_corner[0], held_corner[1], c)};
			corners_held = 0;
		end
	endfunction

	task automatic send_vertex(vertex_t c);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.pos_x <= c.pos_x;
		vtx_ch.pos_y <= c.pos_y;
		vtx_ch.pos_z <= c.pos_z;
		vtx_ch.tex_u <= c.tex_u;
		vtx_ch.tex_v <= c.tex_v;
		do @(posedge clk); while (!vtx_ch.ready);
		accept_corner(c);
	endtask

	task automatic send_triangle(vertex_t a, vertex_t b, vertex_t c);
		send_vertex(a);
		send_vertex(b);
		send_vertex(c);
	endtask

	task automatic wait_drained();
		vtx_ch.valid <= 1'b0;
		while (tangent_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			1: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic vertex_t rand_vertex(int mode);
		return mk_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode));
	endfunction

	task automatic check_tangent();
		tangent_t exp_t;
		if (tangent_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected tangent transaction: x=%h y=%h z=%h deg=%b sat=%b",
					tan_ch.tangent_x, tan_ch.tangent_y, tan_ch.tangent_z,
					tan_ch.degenerate, tan_ch.saturated);
			return;
		end
		exp_t = tangent_q.pop_front();
		if (tan_ch.tangent_x !== exp_t.tx || tan_ch.tangent_y !== exp_t.ty ||
			tan_ch.tangent_z !== exp_t.tz || tan_ch.degenerate !== exp_t.deg ||
			tan_ch.saturated !== exp_t.sat) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tangent mismatch: exp %h %h %h %b %b, got %h %h %h %b %b",
					exp_t.tx, exp_t.ty, exp_t.tz, exp_t.deg, exp_t.sat,
					tan_ch.tangent_x, tan_ch.tangent_y, tan_ch.tangent_z,
					tan_ch.degenerate, tan_ch.saturated);
		end
	endtask

	// Receiver: draws a stall per transaction, or takes a long hold when one is requested.
	initial begin : receiver
		int stall;
		tan_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_fast ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				tan_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tan_ch.ready <= 1'b1;
			do @(posedge clk); while (!tan_ch.valid);
			check_tangent();
		end
	end

	task automatic test_simple_uv();
		// Unit uv square: the tangent equals the first edge.
		send_triangle(mk_vertex(0, 0, 0, 0, 0), mk_vertex(ONE, 2 * ONE, -ONE, ONE, 0),
			mk_vertex(0, ONE, ONE, 0, ONE));
		send_triangle(mk_vertex(ONE, ONE, ONE, ONE, ONE),
			mk_vertex(3 * ONE, ONE, -5 * ONE, 2 * ONE, 3 * ONE),
			mk_vertex(-ONE, 7 * ONE, ONE, 5 * ONE, -ONE));
		// Zero numerator in x: no change of x along either edge.
		send_triangle(mk_vertex(ONE, 0, 0, 0, 0), mk_vertex(ONE, ONE, 0, ONE, 0),
			mk_vertex(ONE, 0, ONE, 0, ONE));
	endtask

	task automatic test_degenerate();
		send_triangle(mk_vertex(0, 0, 0, ONE, ONE), mk_vertex(ONE, 0, 0, ONE, ONE),
			mk_vertex(0, ONE, 0, ONE, ONE));
		// Collinear uv.
		send_triangle(mk_vertex(5, 6, 7, 0, 0), mk_vertex(-3, 2, 9, ONE, 2 * ONE),
			mk_vertex(1, 1, 1, 3 * ONE, 6 * ONE));
	endtask

	task automatic test_saturation();
		send_triangle(mk_vertex(MINV, MINV, MAXV, 0, 0), mk_vertex(MAXV, MAXV, MINV, 1, 0),
			mk_vertex(MINV, MAXV, 0, 0, 1));
		send_triangle(mk_vertex(MAXV, MINV, MAXV, MINV, MINV),
			mk_vertex(MINV, MAXV, MINV, MAXV, MAXV), mk_vertex(MAXV, MAXV, MAXV, MAXV, MINV));
		send_triangle(mk_vertex(MINV, MINV, MINV, MINV, MAXV),
			mk_vertex(MAXV, MAXV, MAXV, MINV, MINV), mk_vertex(0, -1, 1, MAXV, 0));
	endtask

	task automatic test_random(int n_tri);
		int mode;
		vertex_t a, b, c;
		for (int i = 0; i < n_tri; i++) begin
			tx_fast = (i % 100) < 10;
			rx_fast = (i % 100) >= 50 && (i % 100) < 60;
			mode = $urandom_range(0, 9);
			if (mode < 5) mode = 0;
			else if (mode < 7) mode = 1;
			else mode = 2;
			a = rand_vertex(mode);
			b = rand_vertex(mode);
			c = rand_vertex(mode);
			if ($urandom_range(0, 9) == 0) begin
				// Force a zero uv determinant by repeating a uv.
				c.tex_u = a.tex_u;
				c.tex_v = a.tex_v;
			end
			send_triangle(a, b, c);
		end
		tx_fast = 0;
		rx_fast = 0;
	endtask

	task automatic test_backpressure();
		rx_hold = 400;
		tx_fast = 1;
		for (int i = 0; i < 12; i++)
			send_triangle(rand_vertex(0), rand_vertex(1), rand_vertex(0));
		tx_fast = 0;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		vtx_ch.valid <= 1'b0;
		vtx_ch.pos_x <= '0;
		vtx_ch.pos_y <= '0;
		vtx_ch.pos_z <= '0;
		vtx_ch.tex_u <= '0;
		vtx_ch.tex_v <= '0;
		corners_held = 0;
		mismatches = 0;
		rx_hold = 0;
		tx_fast = 0;
		rx_fast = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_simple_uv();
		test_degenerate();
		test_saturation();
		wait_drained();
		test_backpressure();
		test_random(597);
		wait_drained();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && tangent_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
